FILE: rtl/keyed_list_insert_delete_compact_defines.svh
// Assertion macros for the keyed list checker.
// No dependencies; included by kl_checker.sv.
`ifndef KEYED_LIST_INSERT_DELETE_COMPACT_DEFINES_SVH
`define KEYED_LIST_INSERT_DELETE_COMPACT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kl_pkg.sv
// Shared types and codes for the keyed list block.
// No dependencies; used by kl_cell, the top level and the checker.
`timescale 1ns / 1ps

package kl_pkg;

  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int OCOUNT_W = 5;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam status_t ST_APPENDED = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_REMOVED  = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // per-cell control from the top level for the execute cycle
  typedef struct packed {
    logic exec_app;      // append is being committed
    logic exec_del;      // delete is being committed
    logic in_list;       // this cell holds a live entry
    logic at_tail;       // this cell is the first free slot
    logic next_in_list;  // right neighbor holds a live entry
  } cell_ctrl_t;

endpackage

FILE: rtl/keyed_list_insert_delete_compact.sv
// Top level of the keyed list: request/response handshake, fill count, cell row.
// Depends on kl_pkg and kl_cell.
`timescale 1ns / 1ps

// Bounded ordered list of LIST_DEPTH entries (32-bit member number plus
// 16-bit tag) held in a row of cells. A request word is handled in turn:
// the accept cycle registers it, the execute cycle runs every cell's key
// compare at once, ripples the first-hit flag and tag down the row, and
// commits the append or the one-step compacting shift. A new request is
// taken only once the execute cycle is done, so words are not overlapped;
// the execute cycle waits only while an earlier response word still sits
// stalled in the output register. An append lands in the first free cell
// or reports full; a delete removes the frontmost matching entry and
// returns its tag. entry_count carries the count after the request in its
// low 5 bits. No clearing pass: entries beyond the fill count are never read.
module keyed_list_insert_delete_compact #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // request channel
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      req_type,
  input  kl_pkg::key_t              member_id,
  input  kl_pkg::tag_t              entry_tag,
  // response channel
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output kl_pkg::status_t           status,
  output kl_pkg::tag_t              removed_tag,
  output logic [kl_pkg::OCOUNT_W-1:0] entry_count
);
  import kl_pkg::*;

  localparam int COUNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] fill_count;
  logic [COUNT_W-1:0] fill_count_next;
  logic               op_del;       // latched request word
  key_t               op_key;
  tag_t               op_tag;

  logic               req_acc;
  logic               exec;
  logic               full;
  logic               empty;
  status_t            status_next;
  tag_t               removed_next;
  logic [COUNT_W+OCOUNT_W-1:0] count_ext;

  // cell row wiring; index LIST_DEPTH is the end of the chain
  logic       found_c [LIST_DEPTH+1];
  tag_t       tag_c   [LIST_DEPTH+1];
  key_t       key_s   [LIST_DEPTH+1];
  tag_t       tag_s   [LIST_DEPTH+1];
  logic       live    [LIST_DEPTH+1];
  cell_ctrl_t ctrl    [LIST_DEPTH];

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  // commit only when the output register is free or being drained
  assign exec      = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign full  = (fill_count == COUNT_W'(LIST_DEPTH));
  assign empty = (fill_count == '0);

  assign found_c[0]        = 1'b0;
  assign tag_c[0]          = '0;
  assign key_s[LIST_DEPTH] = '0;
  assign tag_s[LIST_DEPTH] = '0;
  assign live[LIST_DEPTH]  = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign live[i] = (COUNT_W'(i) < fill_count);

    always_comb begin
      ctrl[i].exec_app     = exec && (op_del == REQ_APPEND);
      ctrl[i].exec_del     = exec && (op_del == REQ_DELETE);
      ctrl[i].in_list      = live[i];
      ctrl[i].at_tail      = (COUNT_W'(i) == fill_count);
      ctrl[i].next_in_list = live[i+1];
    end

    kl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .srch_key  (op_key),
      .new_tag   (op_tag),
      .found_in  (found_c[i]),
      .tag_in    (tag_c[i]),
      .nxt_key   (key_s[i+1]),
      .nxt_tag   (tag_s[i+1]),
      .key       (key_s[i]),
      .tag       (tag_s[i]),
      .found_out (found_c[i+1]),
      .tag_out   (tag_c[i+1])
    );
  end

  // result of the request in flight
  always_comb begin
    fill_count_next = fill_count;
    removed_next    = '0;
    if (op_del == REQ_APPEND) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next     = ST_APPENDED;
        fill_count_next = fill_count + COUNT_W'(1);
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else if (found_c[LIST_DEPTH]) begin
      status_next     = ST_REMOVED;
      removed_next    = tag_c[LIST_DEPTH];
      fill_count_next = fill_count - COUNT_W'(1);
    end else begin
      status_next = ST_NOTFOUND;
    end
  end

  assign count_ext = {{OCOUNT_W{1'b0}}, fill_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (exec) begin
        fill_count <= fill_count_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      op_del <= req_type;
      op_key <= member_id;
      op_tag <= entry_tag;
    end
    if (exec) begin
      status      <= status_next;
      removed_tag <= removed_next;
      entry_count <= count_ext[OCOUNT_W-1:0];
    end
  end

endmodule

FILE: rtl/kl_cell.sv
// One list slot: key/tag storage, match compare, first-hit chain and shift.
// Depends on kl_pkg.
`timescale 1ns / 1ps

module kl_cell (
  input  logic               clk,
  input  kl_pkg::cell_ctrl_t ctrl,
  input  kl_pkg::key_t       srch_key,
  input  kl_pkg::tag_t       new_tag,
  input  logic               found_in,
  input  kl_pkg::tag_t       tag_in,
  input  kl_pkg::key_t       nxt_key,
  input  kl_pkg::tag_t       nxt_tag,
  output kl_pkg::key_t       key,
  output kl_pkg::tag_t       tag,
  output logic               found_out,
  output kl_pkg::tag_t       tag_out
);
  import kl_pkg::*;

  logic hit;

  assign hit       = ctrl.in_list && (key == srch_key);
  assign found_out = found_in || hit;
  // first hit from the front wins
  assign tag_out   = found_in ? tag_in : (hit ? tag : '0);

  always_ff @(posedge clk) begin
    if (ctrl.exec_app && ctrl.at_tail) begin
      key <= srch_key;
      tag <= new_tag;
    end else if (ctrl.exec_del && found_out && ctrl.next_in_list) begin
      key <= nxt_key;
      tag <= nxt_tag;
    end
  end

endmodule

FILE: rtl/kl_checker.sv
// Port-level checker for the keyed list top level, with its bind.
// Depends on kl_pkg and keyed_list_insert_delete_compact_defines.svh.
`timescale 1ns / 1ps
`include "keyed_list_insert_delete_compact_defines.svh"

module kl_checker #(
  parameter int LIST_DEPTH = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input kl_pkg::status_t             status,
  input kl_pkg::tag_t                removed_tag,
  input logic [kl_pkg::OCOUNT_W-1:0] entry_count
);
  import kl_pkg::*;

  // count ceiling as seen on the port; any value fits once depth exceeds it
  localparam logic [OCOUNT_W-1:0] MAX_CNT = (LIST_DEPTH > 31) ? '1 : OCOUNT_W'(LIST_DEPTH);

  logic req_acc;
  logic rsp_no_rm;

  assign req_acc   = req_valid && !req_stall;
  assign rsp_no_rm = rsp_valid && (status != ST_REMOVED);

  `KL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
  `KL_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_acc, req_stall, "request taken while busy")
  `KL_ASSERT_NOW(a_tag_zero, clk, rst, rsp_no_rm, removed_tag == '0, "removed_tag set without removal")
  `KL_ASSERT_NOW(a_count_range, clk, rst, rsp_valid, entry_count <= MAX_CNT, "entry_count above depth")

endmodule

bind keyed_list_insert_delete_compact kl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_kl_checker (.*);
